>>> hdl/rss_pkg.sv
// Shared types and constants of the run-slice scanline stretcher.
package rss_pkg;

  // Fixed widths of the run and error fields
  localparam int RUN_W   = 11;
  localparam int ERR_W   = 13;
  localparam int COLOR_W = 8;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_DEST_SPAN   = 2'd0;
  localparam logic [1:0] REG_SRC_SPAN    = 2'd1;
  localparam logic [1:0] REG_TRANSPARENT = 2'd2;

  // Register reset values
  localparam logic [COLOR_W-1:0] TRANSPARENT_RESET = 8'hFF;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_SETUP = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

>>> hdl/rss_regs.sv
// APB-style configuration registers of the scanline stretcher.
module rss_regs
  import rss_pkg::*;
#(
  parameter int SPAN_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,
  output logic [SPAN_BITS-1:0] dest_span,
  output logic [SPAN_BITS-1:0] src_span,
  output logic [COLOR_W-1:0]   transparent_color
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Write on the access cycle of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_span         <= SPAN_BITS'(2);
      src_span          <= SPAN_BITS'(1);
      transparent_color <= TRANSPARENT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_DEST_SPAN:   dest_span         <= pwdata[SPAN_BITS-1:0];
        REG_SRC_SPAN:    src_span          <= pwdata[SPAN_BITS-1:0];
        REG_TRANSPARENT: transparent_color <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_index)
      REG_DEST_SPAN:   prdata = DATA_W'(dest_span);
      REG_SRC_SPAN:    prdata = DATA_W'(src_span);
      REG_TRANSPARENT: prdata = DATA_W'(transparent_color);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> hdl/rss_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module rss_div #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic [W-1:0]  dvs;
  logic [W:0]    partial;
  logic [W:0]    diff;
  logic          fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign partial = {remainder, quotient[W-1]};
  assign diff    = partial - {1'b0, dvs};
  assign fits    = !diff[W];

  // Iteration count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CW'(W);
      end else if (count != '0) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvs       <= divisor;
    end else if (count != '0) begin
      remainder <= fits ? diff[W-1:0] : partial[W-1:0];
      quotient  <= {quotient[W-2:0], fits};
    end
  end

endmodule

>>> hdl/run_slice_scanline_stretch.sv
// Run-slice scanline stretcher: one run of destination pixels per source pixel.
//
// Usage: source pixels arrive on the in_valid/in_ready channel, one palette
// index per transfer; each pixel yields exactly one run on the
// out_valid/out_ready channel (color, length, draw flag, line-end mark).
// A line takes src_span+1 pixels; the last one carries line_end.
// dest_span, src_span and transparent_color are set over the APB port at byte
// addresses 0, 4 and 8; the user must set them only while the block is idle,
// which the block itself does not enforce. A pixel inside a line is accepted
// and then emitted. The first pixel of a line with src_span of 2 or more is
// accepted, the iterative divider computes dest_span / src_span, the run
// values are latched and the run is emitted; with src_span below 2 it skips the divide.
// One item is in flight at a time; a finished run sits in the output
// register, and the next pixel may be accepted while it waits. A stalled
// receiver holds the block only in the emit step.
// Reset: registers return to dest_span 2, src_span 1, transparent 255, the
// run values clear and the block waits for the first pixel of a line.
module run_slice_scanline_stretch
  import rss_pkg::*;
#(
  parameter int SPAN_BITS = 11
) (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // pixel input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COLOR_W-1:0]  source_pixel,
  // run output
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLOR_W-1:0]  run_color,
  output logic [RUN_W-1:0]    run_length,
  output logic                draw,
  output logic                line_end
);

  localparam int EW   = ((ERR_W > SPAN_BITS + 2) ? ERR_W : SPAN_BITS + 2) + 1;
  localparam int LENW = (SPAN_BITS + 1 > RUN_W) ? SPAN_BITS + 1 : RUN_W;

  logic [SPAN_BITS-1:0] dest_span;
  logic [SPAN_BITS-1:0] src_span;
  logic [COLOR_W-1:0]   transparent_color;

  state_t               state;
  logic [SPAN_BITS-1:0] pixel_position;
  logic [COLOR_W-1:0]   pixel;
  logic [SPAN_BITS-1:0] base_run;
  logic [SPAN_BITS:0]   error_up;
  logic signed [ERR_W-1:0] error_term;
  logic [SPAN_BITS-1:0] first_run;
  logic [SPAN_BITS-1:0] final_run;

  logic                 in_xfer;
  logic                 line_start;
  logic                 short_line;
  logic                 div_start;
  logic                 div_done;
  logic [SPAN_BITS-1:0] quotient;
  logic [SPAN_BITS-1:0] remainder;

  logic signed [EW-1:0] err_ext;
  logic signed [EW-1:0] up_ext;
  logic signed [EW-1:0] src_ext;
  logic signed [EW-1:0] two_src;
  logic signed [EW-1:0] e_sum;
  logic signed [EW-1:0] e_dec;
  logic signed [EW-1:0] et_setup;
  logic                 step_up;
  logic                 at_start;
  logic                 at_end;
  logic                 last;
  logic [SPAN_BITS:0]   len_sel;
  logic [LENW-1:0]      len_wide;
  logic [SPAN_BITS-1:0] half_run;
  logic                 out_load;

  rss_regs #(
    .SPAN_BITS(SPAN_BITS)
  ) u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .dest_span        (dest_span),
    .src_span         (src_span),
    .transparent_color(transparent_color)
  );

  rss_div #(
    .W(SPAN_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dest_span),
    .divisor  (src_span),
    .done     (div_done),
    .quotient (quotient),
    .remainder(remainder)
  );

  // Input handshake and line start decode
  assign in_ready   = (state == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign line_start = (pixel_position == '0);
  assign short_line = (src_span < SPAN_BITS'(2));
  assign div_start  = in_xfer && line_start && !short_line;

  // Error arithmetic, widened so the sign test sees no wrap
  assign err_ext = EW'(error_term);
  assign up_ext  = $signed({{(EW - SPAN_BITS - 1){1'b0}}, error_up});
  assign src_ext = $signed({{(EW - SPAN_BITS){1'b0}}, src_span});
  assign two_src = $signed({{(EW - SPAN_BITS - 1){1'b0}}, src_span, 1'b0});
  assign e_sum   = err_ext + up_ext;
  assign e_dec   = e_sum - two_src;
  assign step_up = (e_sum > 0);

  // Run values derived from quotient and remainder
  assign et_setup = $signed({{(EW - SPAN_BITS){1'b0}}, remainder}) - two_src +
                    (quotient[0] ? src_ext : '0);
  assign half_run = (quotient >> 1) + SPAN_BITS'(1);

  // Pick the run length for this pixel
  assign at_start = line_start;
  assign at_end   = !line_start && (pixel_position >= src_span);
  assign last     = at_start ? (src_span == '0) : at_end;

  always_comb begin
    if (at_start) begin
      len_sel = {1'b0, first_run};
    end else if (at_end) begin
      len_sel = {1'b0, final_run};
    end else begin
      len_sel = {1'b0, base_run} + {{SPAN_BITS{1'b0}}, step_up};
    end
  end

  assign len_wide = LENW'(len_sel);
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  // Sequencer: accept, divide, latch run values, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pixel_position <= '0;
      base_run       <= '0;
      error_up       <= '0;
      error_term     <= '0;
      first_run      <= '0;
      final_run      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (line_start && !short_line) begin
              state <= S_DIV;
            end else begin
              state <= S_EMIT;
              if (line_start) begin
                base_run   <= '0;
                error_up   <= '0;
                error_term <= '0;
                first_run  <= '0;
                final_run  <= '0;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          base_run   <= quotient;
          error_up   <= {remainder, 1'b0};
          error_term <= et_setup[ERR_W-1:0];
          final_run  <= half_run;
          first_run  <= (remainder == '0 && !quotient[0]) ?
                        half_run - SPAN_BITS'(1) : half_run;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
            if (!at_start && !at_end) begin
              error_term <= step_up ? e_dec[ERR_W-1:0] : e_sum[ERR_W-1:0];
            end
            pixel_position <= last ? '0 : pixel_position + SPAN_BITS'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the accepted pixel
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pixel <= source_pixel;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      run_color  <= pixel;
      run_length <= len_wide[RUN_W-1:0];
      draw       <= (final_run != '0) && (pixel != transparent_color);
      line_end   <= last;
    end
  end

`ifndef SYNTHESIS
  // The divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider completed outside the divide step");

  // A pixel inside a line goes straight to the emit step
  a_mid_to_emit: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !line_start) |=> state == S_EMIT)
    else $error("mid-line pixel did not go to emit");

  // A line-end run restarts the line
  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    (out_load && last) |=> pixel_position == '0)
    else $error("line position not cleared after line end");
`endif

endmodule
